// ===== src/arx_multiply_block_cipher_unit_macros.svh =====
// Assertion macros for the cipher unit checker
`ifndef ARX_MULTIPLY_BLOCK_CIPHER_UNIT_MACROS_SVH
`define ARX_MULTIPLY_BLOCK_CIPHER_UNIT_MACROS_SVH

// assert that antecedent implies consequent in the next cycle
`define AMC_ASSERT_NEXT(lbl, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

// assert that a condition holds every cycle outside reset
`define AMC_ASSERT_ALWAYS(lbl, rst_sig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (cond)) \
    else $error("assertion failed");

`endif

// ===== src/amc_pkg.sv =====
package amc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_CTR     = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_NONCE_LOW  = 1'b0,
    CFG_NONCE_HIGH = 1'b1
  } cfg_idx_t;

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 64;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  key_index;
    logic [31:0] key_word;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [31:0] counter;
    logic        first_block;
    logic [4:0]  valid_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        counter_exhausted;
  } out_item_t;

  // classified job from the front to the back
  typedef struct packed {
    logic         decrypt;
    logic         ctr;
    logic         exhausted;
    logic [127:0] block;
    logic [127:0] data;
    logic [127:0] mask;
  } job_t;

  localparam logic [31:0] FwdMul [4] = '{32'h71e961dd, 32'h47dff15d, 32'h172f4f2f, 32'hf9c1e3c7};
  localparam logic [31:0] InvMul [4] = '{32'hf6e1fe75, 32'h185beaf5, 32'hfb0a57cf, 32'h4d82edf7};
  localparam int RotA = 13;
  localparam int RotB = 7;
  localparam int RotC = 11;
  localparam int RotD = 15;

  function automatic logic [31:0] rol(input logic [31:0] x, input int s);
    rol = (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int s);
    ror = (x >> s) | (x << (32 - s));
  endfunction

endpackage

// ===== src/amc_front.sv =====
module amc_front #(
  parameter int KeyWords = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  amc_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        nonce_low,
  input  logic [31:0]        nonce_high,
  input  logic               back_idle,
  output logic               key_we,
  output logic [$clog2(KeyWords)-1:0] key_addr,
  output logic [31:0]        key_data,
  output amc_pkg::job_t      job,
  output logic               job_valid,
  input  logic               job_ready
);
  import amc_pkg::*;

  // two-entry queue
  job_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  job_t nj;
  logic push, pop, is_job;
  logic [4:0] vb;
  logic [127:0] m;

  // hold key loads until no block is queued or running
  assign in_ready = (cnt != 2'd2) && (is_job || (cnt == 2'd0 && back_idle));
  assign is_job = in_item.operation != OP_LOAD;
  assign push = in_valid && in_ready && is_job;
  assign pop = job_valid && job_ready;
  assign job_valid = (cnt != 2'd0);
  assign job = q[rp];

  assign key_we = in_valid && in_ready && (in_item.operation == OP_LOAD)
                  && ({25'd0, in_item.key_index} < KeyWords);
  assign key_addr = in_item.key_index[$clog2(KeyWords)-1:0];
  assign key_data = in_item.key_word;

  always_comb begin
    vb = (in_item.valid_bytes > 5'd16) ? 5'd16 : in_item.valid_bytes;
    for (int b = 0; b < 16; b++) begin
      m[b*8 +: 8] = (b < vb) ? 8'hff : 8'h00;
    end
    nj.decrypt = in_item.operation == OP_DECRYPT;
    nj.ctr = in_item.operation == OP_CTR;
    nj.exhausted = nj.ctr && in_item.first_block && (&in_item.counter);
    nj.data = {in_item.data_high, in_item.data_low};
    nj.block = nj.ctr ? {in_item.counter, nonce_high, nonce_low} : nj.data;
    nj.mask = m;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= nj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/amc_back.sv =====
module amc_back #(
  parameter int Rounds = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                key_we,
  input  logic [$clog2(4*Rounds)-1:0] key_addr,
  input  logic [31:0]         key_data,
  input  amc_pkg::job_t       job,
  input  logic                job_valid,
  output logic                job_ready,
  output logic                idle,
  output amc_pkg::out_item_t  out_item,
  output logic                out_valid,
  input  logic                out_ready
);
  import amc_pkg::*;

  localparam int KeyWords = 4 * Rounds;
  localparam int Aw = $clog2(KeyWords);
  localparam int Rw = $clog2(Rounds + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MIX  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_KEY  = 7'b0001000,
    S_XOR  = 7'b0010000,
    S_UMIX = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  logic [31:0] mem [KeyWords];
  logic [31:0] krd;
  logic [Aw-1:0] lin, kaddr;
  logic [1:0] step, wi;
  logic [Rw-1:0] rnd;
  logic [31:0] w [4];
  logic [31:0] mixw, mres;
  state_t state;
  job_t cur;
  logic [127:0] blk, res;
  logic last_rnd;

  assign idle = (state == S_IDLE);
  assign job_ready = idle && (!out_valid || out_ready);
  assign last_rnd = (rnd == Rw'(Rounds - 1));

  // key position for this round and word; decryption walks the keys backwards
  always_comb begin
    lin = Aw'({rnd, 2'b00}) + Aw'(step);
    kaddr = cur.decrypt ? (Aw'(KeyWords - 1) - lin) : lin;
  end

  // the key read is registered: its address is presented in the cycle before the xor
  always_ff @(posedge clk) begin
    if (key_we) mem[key_addr] <= key_data;
    krd <= mem[kaddr];
  end

  always_comb begin
    // unmixing runs the words from the top down
    wi = (state == S_UMIX) ? ~step : step;
    mres = w[step] * (cur.decrypt ? InvMul[step] : FwdMul[step]);
    case (wi)
      2'd0: mixw = cur.decrypt ? ror(w[0] - w[1] - w[2] - w[3], RotA)
                               : rol(w[0], RotA) + w[1] + w[2] + w[3];
      2'd1: mixw = cur.decrypt ? ror(w[1] - w[2] - w[3] - w[0], RotB)
                               : rol(w[1], RotB) + w[2] + w[3] + w[0];
      2'd2: mixw = cur.decrypt ? ror(w[2] - w[3] - w[0] - w[1], RotC)
                               : rol(w[2], RotC) + w[3] + w[0] + w[1];
      default: mixw = cur.decrypt ? ror(w[3] - w[0] - w[1] - w[2], RotD)
                                  : rol(w[3], RotD) + w[0] + w[1] + w[2];
    endcase
    blk = {w[3], w[2], w[1], w[0]};
    res = cur.ctr ? ((blk ^ cur.data) & cur.mask) : blk;
    if (cur.exhausted) res = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid && job_ready) state <= job.decrypt ? S_KEY : S_MIX;
        end
        S_MIX: begin
          if (step == 2'd3) state <= S_MUL;
        end
        S_MUL: begin
          if (!cur.decrypt) state <= S_XOR;
          else if (step == 2'd3) state <= S_UMIX;
          else state <= S_KEY;
        end
        S_KEY: state <= S_XOR;
        S_XOR: begin
          if (cur.decrypt || step != 2'd3) state <= S_MUL;
          else if (last_rnd) state <= S_DONE;
          else state <= S_MIX;
        end
        S_UMIX: begin
          if (step == 2'd3) state <= last_rnd ? S_DONE : S_KEY;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (job_valid && job_ready) begin
          cur <= job;
          w[0] <= job.block[31:0];
          w[1] <= job.block[63:32];
          w[2] <= job.block[95:64];
          w[3] <= job.block[127:96];
          step <= 2'd0;
          rnd <= '0;
        end
      end
      S_MIX: begin
        w[wi] <= mixw;
        step <= step + 2'd1;
      end
      S_UMIX: begin
        w[wi] <= mixw;
        step <= step + 2'd1;
        if (step == 2'd3 && !last_rnd) rnd <= rnd + Rw'(1);
      end
      S_MUL: begin
        w[step] <= mres;
        if (cur.decrypt) step <= step + 2'd1;
      end
      S_XOR: begin
        w[step] <= w[step] ^ krd;
        if (!cur.decrypt) begin
          step <= step + 2'd1;
          if (step == 2'd3 && !last_rnd) rnd <= rnd + Rw'(1);
        end
      end
      S_DONE: begin
        out_item.result_low <= res[63:0];
        out_item.result_high <= res[127:64];
        out_item.counter_exhausted <= cur.exhausted;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/arx_multiply_block_cipher_unit.sv =====
// Each accepted encrypt, decrypt or CTR beat yields one result once its rounds have run,
// and decrypt takes longer than encrypt or CTR; a key load takes effect at its accepting edge, no result.
// Blocks run one at a time through the shared round datapath; two blocks may queue ahead,
// and key loads wait until the queue is empty and the datapath is idle.
// Reset (rst, synchronous) clears the queue, sequencer, output valid and nonce;
// key words stay undefined until written.
module arx_multiply_block_cipher_unit #(
  parameter int ROUNDS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  amc_pkg::in_item_t   in_item,
  input  logic                in_valid,
  output logic                in_ready,
  output amc_pkg::out_item_t  out_item,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_we,
  input  logic [amc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [amc_pkg::CfgDataW-1:0] cfg_data
);
  import amc_pkg::*;

  localparam int KeyWords = 4 * ROUNDS;

  logic [63:0] nonce_low;
  logic [31:0] nonce_high;
  logic key_we;
  logic [$clog2(KeyWords)-1:0] key_addr;
  logic [31:0] key_data;
  job_t job;
  logic job_valid, job_ready, back_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      nonce_low <= '0;
      nonce_high <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NONCE_LOW) nonce_low <= cfg_data;
      else nonce_high <= cfg_data[31:0];
    end
  end

  amc_front #(.KeyWords(KeyWords)) u_front (
    .clk, .rst, .in_item, .in_valid, .in_ready, .nonce_low, .nonce_high, .back_idle,
    .key_we, .key_addr, .key_data, .job, .job_valid, .job_ready
  );

  // back takes a job only when idle and the output register is free or being drained
  amc_back #(.Rounds(ROUNDS)) u_back (
    .clk, .rst, .key_we, .key_addr, .key_data, .job, .job_valid,
    .job_ready, .idle(back_idle), .out_item, .out_valid, .out_ready
  );

endmodule

// ===== src/amc_checker.sv =====
`include "arx_multiply_block_cipher_unit_macros.svh"
module amc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input amc_pkg::out_item_t out_item,
  input logic               out_valid,
  input logic               out_ready
);
  logic exh_bad;

  assign exh_bad = out_valid && out_item.counter_exhausted
                   && (|{out_item.result_high, out_item.result_low});

  `AMC_ASSERT_NEXT(out_hold, rst, out_valid && !out_ready, out_valid && $stable(out_item))
  `AMC_ASSERT_ALWAYS(exh_zero, rst, !exh_bad)
  `AMC_ASSERT_NEXT(rst_clear, 1'b0, rst, !out_valid)
  `AMC_ASSERT_NEXT(rst_ready, 1'b0, rst, in_ready)
endmodule

bind arx_multiply_block_cipher_unit amc_checker u_chk (
  .clk, .rst, .in_ready, .out_item, .out_valid, .out_ready
);

// ===== verif/arx_multiply_block_cipher_unit_tb.sv =====
`timescale 1ns / 1ps

module arx_multiply_block_cipher_unit_tb;
  import amc_pkg::*;

  localparam int ROUNDS = 10;
  localparam int KEY_WORDS = 4 * ROUNDS;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 13 * ROUNDS + 20;
  localparam int IN_BITS = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_item_t in_item = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  out_item_t out_item;
  logic out_valid;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  arx_multiply_block_cipher_unit #(.ROUNDS(ROUNDS)) dut (
    .clk(clk), .rst(rst),
    .in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
    .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic [31:0] key_mem [KEY_WORDS];
  logic [63:0] nonce_lo = '0;
  logic [31:0] nonce_hi = '0;
  out_item_t   blocks_due [$];
  logic [127:0] last_cipher = '0;
  int  err_cnt = 0;
  int  stall_cnt = 0;
  bit  quiet = 1'b0;
  bit  running = 1'b0;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int s);
    logic [63:0] d;
    d = {x, x};
    return d[(63 - s) -: 32];
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int s);
    logic [63:0] d;
    d = {x, x};
    return d[s +: 32];
  endfunction

  function automatic logic [127:0] mix_forward(input logic [127:0] b);
    logic [31:0] w [4];
    for (int i = 0; i < 4; i++) w[i] = b[32*i +: 32];
    for (int r = 0; r < ROUNDS; r++) begin
      w[0] = rot_left(w[0], 13) + w[1] + w[2] + w[3];
      w[1] = rot_left(w[1], 7) + w[2] + w[3] + w[0];
      w[2] = rot_left(w[2], 11) + w[3] + w[0] + w[1];
      w[3] = rot_left(w[3], 15) + w[0] + w[1] + w[2];
      for (int i = 0; i < 4; i++) begin
        w[i] = w[i] * FwdMul[i];
        w[i] = w[i] ^ key_mem[4*r + i];
      end
    end
    return {w[3], w[2], w[1], w[0]};
  endfunction

  function automatic logic [127:0] mix_inverse(input logic [127:0] b);
    logic [31:0] w [4];
    for (int i = 0; i < 4; i++) w[i] = b[32*i +: 32];
    for (int r = 0; r < ROUNDS; r++) begin
      for (int i = 0; i < 4; i++) begin
        w[i] = w[i] ^ key_mem[KEY_WORDS - 1 - (4*r + i)];
        w[i] = w[i] * InvMul[i];
      end
      w[3] = rot_right(w[3] - w[0] - w[1] - w[2], 15);
      w[2] = rot_right(w[2] - w[3] - w[0] - w[1], 11);
      w[1] = rot_right(w[1] - w[2] - w[3] - w[0], 7);
      w[0] = rot_right(w[0] - w[1] - w[2] - w[3], 13);
    end
    return {w[3], w[2], w[1], w[0]};
  endfunction

  // returns 1 when the beat yields a block, and updates the key store on loads
  function automatic bit cipher_block(input in_item_t it, output out_item_t res);
    logic [127:0] r, ks, mask;
    int nb;
    res = '0;
    case (op_t'(it.operation))
      OP_LOAD: begin
        if (it.key_index < KEY_WORDS) key_mem[it.key_index] = it.key_word;
        return 1'b0;
      end
      OP_ENCRYPT: r = mix_forward({it.data_high, it.data_low});
      OP_DECRYPT: r = mix_inverse({it.data_high, it.data_low});
      default: begin
        if (it.first_block && it.counter == 32'hffffffff) begin
          res.counter_exhausted = 1'b1;
          return 1'b1;
        end
        nb = (it.valid_bytes > 16) ? 16 : it.valid_bytes;
        ks = mix_forward({it.counter, nonce_hi, nonce_lo});
        mask = (nb == 0) ? '0 : ({128{1'b1}} >> (128 - 8*nb));
        r = ({it.data_high, it.data_low} ^ ks) & mask;
      end
    endcase
    res.result_low = r[63:0];
    res.result_high = r[127:64];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (running && out_valid && out_ready) begin
      if (blocks_due.size() == 0) begin
        report_mismatch("unexpected block", {out_item.result_high, out_item.result_low}, '0);
      end else begin
        w = blocks_due.pop_front();
        if (out_item.result_low !== w.result_low)
          report_mismatch("result_low", 128'(out_item.result_low), 128'(w.result_low));
        if (out_item.result_high !== w.result_high)
          report_mismatch("result_high", 128'(out_item.result_high), 128'(w.result_high));
        if (out_item.counter_exhausted !== w.counter_exhausted)
          report_mismatch("counter_exhausted", 128'(out_item.counter_exhausted),
                          128'(w.counter_exhausted));
      end
    end
  end

  always @(posedge clk) begin
    if (!running) out_ready <= 1'b0;
    else out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk) begin
    if (running) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    bit has;
    if (!quiet)
      while ($urandom_range(0, 99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = cipher_block(it, res);
    if (has) begin
      blocks_due.push_back(typed ? want : res);
      if (op_t'(it.operation) == OP_ENCRYPT) last_cipher = {res.result_high, res.result_low};
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_nonce(input logic [63:0] lo, input logic [31:0] hi);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NONCE_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_NONCE_HIGH;
    cfg_data <= {32'h0, hi};
    @(posedge clk);
    cfg_we <= 1'b0;
    nonce_lo = lo;
    nonce_hi = hi;
  endtask

  function automatic in_item_t beat(input op_t op, input logic [6:0] idx,
                                    input logic [31:0] kw, input logic [63:0] dl,
                                    input logic [63:0] dh, input logic [31:0] ctr,
                                    input logic fb, input logic [4:0] vb);
    in_item_t it;
    it.operation = op;
    it.key_index = idx;
    it.key_word = kw;
    it.data_low = dl;
    it.data_high = dh;
    it.counter = ctr;
    it.first_block = fb;
    it.valid_bytes = vb;
    return it;
  endfunction

  function automatic in_item_t random_beat();
    in_item_t it;
    int pick;
    it = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.operation = OP_LOAD;
      if ($urandom_range(0, 3) != 0) it.key_index = 7'($urandom_range(0, KEY_WORDS - 1));
    end else if (pick < 40) begin
      it.operation = OP_ENCRYPT;
    end else if (pick < 65) begin
      it.operation = OP_DECRYPT;
      // round-trip the last ciphertext now and then
      if ($urandom_range(0, 2) == 0) {it.data_high, it.data_low} = last_cipher;
    end else begin
      it.operation = OP_CTR;
      if ($urandom_range(0, 9) == 0) it.counter = 32'hffffffff;
      if ($urandom_range(0, 2) != 0) it.valid_bytes = 5'($urandom_range(1, 16));
    end
    return it;
  endfunction

  initial begin
    stim_row_t rows [$];
    out_item_t none;
    none = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    running = 1'b1;
    @(posedge clk);

    for (int k = 0; k < KEY_WORDS; k++)
      send_beat(beat(OP_LOAD, 7'(k), $urandom, '0, '0, '0, 1'b0, '0), 1'b0, none);

    rows.push_back('{beat(OP_LOAD, 7'd40, 32'hdeadbeef, '0, '0, '0, 1'b0, '0), 1'b0, none});
    rows.push_back('{beat(OP_LOAD, 7'd127, 32'hffffffff, '0, '0, '0, 1'b0, '0), 1'b0, none});
    rows.push_back('{beat(OP_ENCRYPT, '0, '0, '0, '0, '0, 1'b0, '0), 1'b0, none});
    rows.push_back('{beat(OP_ENCRYPT, '1, '1, '1, '1, '1, 1'b1, '1), 1'b0, none});
    rows.push_back('{beat(OP_DECRYPT, '0, '0, '0, '0, '0, 1'b0, '0), 1'b0, none});
    rows.push_back('{beat(OP_DECRYPT, '1, '1, '1, '1, '1, 1'b1, '1), 1'b0, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'hffffffff, 1'b1, 5'd16), 1'b1,
                     '{result_low: '0, result_high: '0, counter_exhausted: 1'b1}});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'hffffffff, 1'b0, 5'd16), 1'b0, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'h1234, 1'b1, 5'd0), 1'b1, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'h0, 1'b1, 5'd1), 1'b0, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'h5, 1'b0, 5'd8), 1'b0, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'h6, 1'b0, 5'd9), 1'b0, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'h7, 1'b0, 5'd15), 1'b0, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '0, '0, 32'h8, 1'b0, 5'd16), 1'b0, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'h9, 1'b0, 5'd17), 1'b0, none});
    rows.push_back('{beat(OP_CTR, '0, '0, '1, '1, 32'ha, 1'b0, 5'd31), 1'b0, none});
    rows.push_back('{beat(OP_ENCRYPT, '0, '0, 64'h0123456789abcdef, '1, 32'hffffffff, 1'b1,
                          5'd0), 1'b0, none});
    rows.push_back('{beat(OP_LOAD, 7'd39, 32'h0, '0, '0, '0, 1'b0, '0), 1'b0, none});
    rows.push_back('{beat(OP_DECRYPT, '0, '0, 64'h0123456789abcdef, 64'h5a5a, '1, 1'b1,
                          5'd3), 1'b0, none});
    foreach (rows[i]) send_beat(rows[i].item, rows[i].typed, rows[i].want);

    write_nonce('1, '1);
    for (int ph = 0; ph < 4; ph++) begin
      quiet = (ph == 1);
      for (int n = 0; n < 175; n++) begin
        send_beat(random_beat(), 1'b0, none);
        // hold off once until the pipeline has emptied
        if (ph == 2 && n == 80) drain();
      end
      if (ph == 0) write_nonce('0, '0);
      else if (ph < 3) write_nonce({$urandom, $urandom}, $urandom);
    end
    quiet = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
